/* hw/rtl/sac_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_pkg
// Shared constants and codes of the suffix automaton common substring block.
// ----------------------------------------------------------------------------
package sac_pkg;

   localparam int MAX_TEXT_DEF = 4096;
   localparam int ALPHABET_DEF = 26;

   localparam int KIND_W = 2;
   localparam int SYM_W  = 5;
   localparam int MLEN_W = 13;
   localparam int POS_W  = 16;

   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MATCH  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

endpackage

/* hw/rtl/sac_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_ram
// Simple dual-port memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sac_ram #(
   parameter int DEPTH  = 8191,
   parameter int ADDR_W = 13,
   parameter int DATA_W = 13
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/suffix_automaton_common_substring.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suffix_automaton_common_substring
// Online suffix automaton over a text, matched against a query symbol by
// symbol; reports current match, longest common substring and its end.
//
//   channel | ports                                        | dir
//   req     | req_valid req_ready req_kind req_symbol req_first | in
//   rsp     | rsp_valid rsp_ready rsp_match_len rsp_best_len
//           | rsp_best_end rsp_full_res                    | out
//
// One item at a time; every transition, link or length access goes through
// a memory port with a registered read. Clear rewrites the root row. Match
// follows suffix links until a transition exists. Append walks the links,
// clears the new row and walks again; a clone copies the split state's row.
// After reset the root row is cleared with req_ready low.
// A result waiting on rsp_ready holds the next item in its final step.
// ----------------------------------------------------------------------------
module suffix_automaton_common_substring #(
   parameter int MAX_TEXT = sac_pkg::MAX_TEXT_DEF,
   parameter int ALPHABET = sac_pkg::ALPHABET_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [sac_pkg::KIND_W-1:0] req_kind,
   input  logic [sac_pkg::SYM_W-1:0] req_symbol,
   input  logic                      req_first,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [sac_pkg::MLEN_W-1:0] rsp_match_len,
   output logic [sac_pkg::MLEN_W-1:0] rsp_best_len,
   output logic [sac_pkg::POS_W-1:0] rsp_best_end,
   output logic                      rsp_full_res
);

   localparam int NSTATES = 2 * MAX_TEXT - 1;
   localparam int SW      = $clog2(2 * MAX_TEXT);
   localparam int LW      = $clog2(MAX_TEXT + 1);
   localparam int CW      = $clog2(ALPHABET);
   localparam int TAW     = SW + CW;
   localparam int PW      = sac_pkg::POS_W;

   typedef enum logic [13:0] {
      S_INIT   = 14'b00000000000001,
      S_IDLE   = 14'b00000000000010,
      S_AW1    = 14'b00000000000100,
      S_AQLEN  = 14'b00000000001000,
      S_ACLR   = 14'b00000000010000,
      S_AW2    = 14'b00000000100000,
      S_AFIN   = 14'b00000001000000,
      S_ACLINK = 14'b00000010000000,
      S_ACPW   = 14'b00000100000000,
      S_AW3    = 14'b00001000000000,
      S_AQLINK = 14'b00010000000000,
      S_ANLINK = 14'b00100000000000,
      S_MW     = 14'b01000000000000,
      S_DONE   = 14'b10000000000000
   } state_type;

   state_type st_ff, st_in;
   logic [SW-1:0] p_ff, p_in, q_ff, q_in, nl_ff, nl_in, cl_ff, cl_in;
   logic [SW-1:0] count_ff, count_in, last_ff, last_in, mst_ff, mst_in;
   logic [CW-1:0] k_ff, k_in, c_ff, c_in;
   logic [LW-1:0] plen_ff, plen_in, last_len_ff, last_len_in;
   logic [LW-1:0] cur_ff, cur_in, best_ff, best_in;
   logic [PW-1:0] bend_ff, bend_in, qpos_ff, qpos_in, pos_ff, pos_in;
   logic found_ff, found_in, need2_ff, need2_in, walked_ff, walked_in;
   logic full_ff, full_in, clr_ff, clr_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [sac_pkg::MLEN_W-1:0] rsp_match_len_ff, rsp_match_len_in;
   logic [sac_pkg::MLEN_W-1:0] rsp_best_len_ff, rsp_best_len_in;
   logic [PW-1:0] rsp_best_end_ff, rsp_best_end_in;
   logic rsp_full_res_ff, rsp_full_res_in;

   logic           t_we, l_we, n_we;
   logic [TAW-1:0] t_waddr, t_raddr;
   logic [SW-1:0]  t_wdata, t_rdata;
   logic [SW-1:0]  l_waddr, l_raddr, l_wdata, l_rdata;
   logic [SW-1:0]  n_waddr, n_raddr;
   logic [LW-1:0]  n_wdata, n_rdata;

   sac_ram #(.DEPTH(NSTATES * (2 ** CW)), .ADDR_W(TAW), .DATA_W(SW)) u_trans (
      .clock(clock), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
      .raddr(t_raddr), .rdata(t_rdata));

   sac_ram #(.DEPTH(NSTATES), .ADDR_W(SW), .DATA_W(SW)) u_link (
      .clock(clock), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
      .raddr(l_raddr), .rdata(l_rdata));

   sac_ram #(.DEPTH(NSTATES), .ADDR_W(SW), .DATA_W(LW)) u_len (
      .clock(clock), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
      .raddr(n_raddr), .rdata(n_rdata));

   logic           sym_ok, stale, fin_append;
   logic [PW-1:0]  pos_base;
   logic [LW-1:0]  nc;
   logic [SW:0]    cnt_need;

   always_comb begin
      st_in = st_ff; p_in = p_ff; q_in = q_ff; nl_in = nl_ff; cl_in = cl_ff;
      count_in = count_ff; last_in = last_ff; mst_in = mst_ff;
      k_in = k_ff; c_in = c_ff; plen_in = plen_ff; last_len_in = last_len_ff;
      cur_in = cur_ff; best_in = best_ff; bend_in = bend_ff; qpos_in = qpos_ff;
      pos_in = pos_ff; found_in = found_ff; need2_in = need2_ff;
      walked_in = walked_ff; full_in = full_ff; clr_in = clr_ff;
      rsp_match_len_in = rsp_match_len_ff; rsp_best_len_in = rsp_best_len_ff;
      rsp_best_end_in = rsp_best_end_ff; rsp_full_res_in = rsp_full_res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      t_we = 1'b0; t_waddr = {nl_ff, k_ff}; t_wdata = '0;
      l_we = 1'b0; l_waddr = nl_ff; l_wdata = '0;
      n_we = 1'b0; n_waddr = nl_ff; n_wdata = '0;
      t_raddr = {p_ff, c_ff}; l_raddr = p_ff; n_raddr = p_ff;

      sym_ok   = {4'b0, req_symbol} < 9'(ALPHABET);
      stale    = req_first || (mst_ff >= count_ff);
      pos_base = req_first ? '0 : qpos_ff;
      nc       = '0;
      cnt_need = '0;
      fin_append = 1'b0;

      case (st_ff)
         S_INIT: begin
            t_we = 1'b1; t_waddr = {{SW{1'b0}}, k_ff};
            l_we = 1'b1; l_waddr = '0;
            n_we = 1'b1; n_waddr = '0;
            k_in = CW'(k_ff + 1'b1);
            if (k_ff == CW'(ALPHABET - 1)) begin
               k_in  = '0;
               clr_in = 1'b0;
               st_in = clr_ff ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               c_in    = CW'(req_symbol);
               full_in = 1'b0;
               st_in   = S_DONE;
               case (req_kind)
                  sac_pkg::KIND_CLEAR: begin
                     count_in = SW'(1); last_in = '0; last_len_in = '0;
                     mst_in = '0; cur_in = '0; k_in = '0;
                     clr_in = 1'b1; st_in = S_INIT;
                  end
                  sac_pkg::KIND_APPEND: begin
                     if (sym_ok) begin
                        if (last_len_ff >= LW'(MAX_TEXT)) begin
                           full_in = 1'b1;
                        end else begin
                           p_in = last_ff; found_in = 1'b0;
                           t_raddr = {last_ff, c_in}; l_raddr = last_ff;
                           n_raddr = last_ff;
                           st_in = S_AW1;
                        end
                     end
                  end
                  sac_pkg::KIND_MATCH: begin
                     if (req_first) begin
                        best_in = '0; bend_in = '0;
                     end
                     pos_in  = pos_base;
                     qpos_in = (pos_base == '1) ? pos_base : PW'(pos_base + 1'b1);
                     if (!sym_ok) begin
                        mst_in = '0; cur_in = '0;
                     end else begin
                        p_in = stale ? '0 : mst_ff;
                        cur_in = stale ? '0 : cur_ff;
                        walked_in = 1'b0;
                        t_raddr = {p_in, c_in}; l_raddr = p_in; n_raddr = p_in;
                        st_in = S_MW;
                     end
                  end
                  default: begin
                     st_in = S_DONE;
                  end
               endcase
            end
         end
         S_MW: begin
            if (t_rdata != '0) begin
               mst_in = t_rdata;
               nc = LW'((walked_ff ? n_rdata : cur_ff) + 1'b1);
               cur_in = nc;
               if (nc > best_ff) begin
                  best_in = nc; bend_in = pos_ff;
               end
               st_in = S_DONE;
            end else if (p_ff == '0) begin
               mst_in = '0; cur_in = '0; st_in = S_DONE;
            end else begin
               p_in = l_rdata; walked_in = 1'b1;
               t_raddr = {l_rdata, c_ff}; l_raddr = l_rdata; n_raddr = l_rdata;
            end
         end
         S_AW1: begin
            if (t_rdata != '0) begin
               found_in = 1'b1; q_in = t_rdata; plen_in = n_rdata;
               n_raddr = t_rdata; st_in = S_AQLEN;
            end else if (p_ff == '0) begin
               found_in = 1'b0; st_in = S_AQLEN;
            end else begin
               p_in = l_rdata;
               t_raddr = {l_rdata, c_ff}; l_raddr = l_rdata; n_raddr = l_rdata;
            end
         end
         S_AQLEN: begin
            need2_in = found_ff && (n_rdata != LW'(plen_ff + 1'b1));
            cnt_need = {1'b0, count_ff} + (need2_in ? (SW+1)'(2) : (SW+1)'(1));
            if (cnt_need > (SW+1)'(NSTATES)) begin
               full_in = 1'b1; st_in = S_DONE;
            end else begin
               nl_in = count_ff; count_in = SW'(count_ff + 1'b1);
               n_we = 1'b1; n_waddr = count_ff;
               n_wdata = LW'(last_len_ff + 1'b1);
               k_in = '0; st_in = S_ACLR;
            end
         end
         S_ACLR: begin
            t_we = 1'b1; t_waddr = {nl_ff, k_ff};
            k_in = CW'(k_ff + 1'b1);
            if (k_ff == CW'(ALPHABET - 1)) begin
               k_in = '0; p_in = last_ff;
               t_raddr = {last_ff, c_ff}; l_raddr = last_ff;
               st_in = S_AW2;
            end
         end
         S_AW2: begin
            if (t_rdata != '0) begin
               st_in = S_AFIN;
            end else begin
               t_we = 1'b1; t_waddr = {p_ff, c_ff}; t_wdata = nl_ff;
               if (p_ff == '0) begin
                  st_in = S_AFIN;
               end else begin
                  p_in = l_rdata;
                  t_raddr = {l_rdata, c_ff}; l_raddr = l_rdata;
               end
            end
         end
         S_AFIN: begin
            if (!found_ff) begin
               l_we = 1'b1; l_waddr = nl_ff; l_wdata = '0; fin_append = 1'b1;
            end else if (!need2_ff) begin
               l_we = 1'b1; l_waddr = nl_ff; l_wdata = q_ff; fin_append = 1'b1;
            end else begin
               cl_in = count_ff; count_in = SW'(count_ff + 1'b1);
               l_raddr = q_ff; st_in = S_ACLINK;
            end
         end
         S_ACLINK: begin
            l_we = 1'b1; l_waddr = cl_ff; l_wdata = l_rdata;
            n_we = 1'b1; n_waddr = cl_ff; n_wdata = LW'(plen_ff + 1'b1);
            k_in = '0; t_raddr = {q_ff, {CW{1'b0}}};
            st_in = S_ACPW;
         end
         S_ACPW: begin
            t_we = 1'b1; t_waddr = {cl_ff, k_ff}; t_wdata = t_rdata;
            if (k_ff == CW'(ALPHABET - 1)) begin
               k_in = '0;
               t_raddr = {p_ff, c_ff}; l_raddr = p_ff;
               st_in = S_AW3;
            end else begin
               k_in = CW'(k_ff + 1'b1);
               t_raddr = {q_ff, k_in};
            end
         end
         S_AW3: begin
            if (t_rdata != q_ff) begin
               st_in = S_AQLINK;
            end else begin
               t_we = 1'b1; t_waddr = {p_ff, c_ff}; t_wdata = cl_ff;
               if (p_ff == '0) begin
                  st_in = S_AQLINK;
               end else begin
                  p_in = l_rdata;
                  t_raddr = {l_rdata, c_ff}; l_raddr = l_rdata;
               end
            end
         end
         S_AQLINK: begin
            l_we = 1'b1; l_waddr = q_ff; l_wdata = cl_ff;
            st_in = S_ANLINK;
         end
         S_ANLINK: begin
            l_we = 1'b1; l_waddr = nl_ff; l_wdata = cl_ff;
            fin_append = 1'b1;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_match_len_in = sac_pkg::MLEN_W'(cur_ff);
               rsp_best_len_in  = sac_pkg::MLEN_W'(best_ff);
               rsp_best_end_in  = bend_ff;
               rsp_full_res_in  = full_ff;
               st_in = S_IDLE;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase

      if (fin_append) begin
         last_in = nl_ff; last_len_in = LW'(last_len_ff + 1'b1);
         st_in = S_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_INIT; k_ff <= '0; clr_ff <= 1'b0;
         count_ff <= SW'(1); last_ff <= '0; last_len_ff <= '0;
         mst_ff <= '0; cur_ff <= '0; best_ff <= '0; bend_ff <= '0;
         qpos_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in; k_ff <= k_in; clr_ff <= clr_in;
         count_ff <= count_in; last_ff <= last_in; last_len_ff <= last_len_in;
         mst_ff <= mst_in; cur_ff <= cur_in; best_ff <= best_in;
         bend_ff <= bend_in; qpos_ff <= qpos_in; rsp_valid_ff <= rsp_valid_in;
      end
      p_ff <= p_in; q_ff <= q_in; nl_ff <= nl_in; cl_ff <= cl_in;
      c_ff <= c_in; plen_ff <= plen_in; pos_ff <= pos_in;
      found_ff <= found_in; need2_ff <= need2_in; walked_ff <= walked_in;
      full_ff <= full_in;
      rsp_match_len_ff <= rsp_match_len_in; rsp_best_len_ff <= rsp_best_len_in;
      rsp_best_end_ff <= rsp_best_end_in; rsp_full_res_ff <= rsp_full_res_in;
   end

   assign req_ready     = (st_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_match_len = rsp_match_len_ff;
   assign rsp_best_len  = rsp_best_len_ff;
   assign rsp_best_end  = rsp_best_end_ff;
   assign rsp_full_res  = rsp_full_res_ff;

endmodule

/* tb/suffix_automaton_common_substring_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suffix_automaton_common_substring_tb
// Builds texts online, runs queries against them and checks every response
// against a behavioral suffix automaton kept in the bench. Covers clears,
// clones, invalid symbols, the unused kind and query restarts, with random
// idles on both channels.
// ----------------------------------------------------------------------------
module suffix_automaton_common_substring_tb;

   localparam int TEXT_CAP   = sac_pkg::MAX_TEXT_DEF;
   localparam int NUM_SYM    = sac_pkg::ALPHABET_DEF;
   localparam int NUM_STATES = 2 * TEXT_CAP - 1;
   localparam int CYCLE_LIMIT = 4000000;

   typedef struct packed {
      logic [sac_pkg::KIND_W-1:0] kind;
      logic [sac_pkg::SYM_W-1:0]  symbol;
      logic                       first;
   } sym_item_type;

   typedef struct packed {
      logic [sac_pkg::MLEN_W-1:0] match_len;
      logic [sac_pkg::MLEN_W-1:0] best_len;
      logic [sac_pkg::POS_W-1:0]  best_end;
      logic                       full_res;
   } match_rsp_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [sac_pkg::KIND_W-1:0]   req_kind = '0;
   logic [sac_pkg::SYM_W-1:0]    req_symbol = '0;
   logic                         req_first = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [sac_pkg::MLEN_W-1:0]   rsp_match_len;
   logic [sac_pkg::MLEN_W-1:0]   rsp_best_len;
   logic [sac_pkg::POS_W-1:0]    rsp_best_end;
   logic                         rsp_full_res;

   sym_item_type  pending_items[$];
   match_rsp_type expected_rsps[$];
   int unsigned cycle_cnt = 0;
   int unsigned mismatch_cnt = 0;
   int unsigned rsp_cnt = 0;
   int unsigned append_cnt = 0;
   int unsigned match_cnt = 0;
   int unsigned drop_cnt = 0;
   int unsigned clone_cnt = 0;
   int unsigned top_best = 0;

   // automaton and query state
   bit [12:0] sam_next [NUM_STATES*NUM_SYM];
   bit [12:0] sam_link [NUM_STATES];
   bit [12:0] sam_len [NUM_STATES];
   int unsigned sam_count, sam_last;
   int unsigned qry_state, qry_len, qry_best, qry_best_end, qry_pos;

   suffix_automaton_common_substring uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_symbol(req_symbol), .req_first(req_first),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_match_len(rsp_match_len), .rsp_best_len(rsp_best_len),
      .rsp_best_end(rsp_best_end), .rsp_full_res(rsp_full_res)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void clear_automaton();
      sam_count = 1;
      sam_last = 0;
      sam_link[0] = 0;
      sam_len[0] = 0;
      for (int i = 0; i < NUM_SYM; i++) sam_next[i] = 0;
      qry_state = 0;
      qry_len = 0;
   endfunction

   function automatic bit extend_text(int unsigned c);
      int unsigned p, q, nl, cl, need;
      bit found;
      p = sam_last;
      q = 0;
      found = 0;
      if (sam_len[sam_last] >= TEXT_CAP) return 1;
      forever begin
         if (sam_next[p*NUM_SYM+c] != 0) begin
            found = 1;
            q = sam_next[p*NUM_SYM+c];
            break;
         end
         if (p == 0) break;
         p = sam_link[p];
      end
      need = (found && sam_len[q] != sam_len[p] + 1) ? 2 : 1;
      if (sam_count + need > NUM_STATES) return 1;
      nl = sam_count++;
      sam_len[nl] = sam_len[sam_last] + 1;
      for (int i = 0; i < NUM_SYM; i++) sam_next[nl*NUM_SYM+i] = 0;
      p = sam_last;
      forever begin
         if (sam_next[p*NUM_SYM+c] != 0) break;
         sam_next[p*NUM_SYM+c] = nl;
         if (p == 0) break;
         p = sam_link[p];
      end
      if (!found) begin
         sam_link[nl] = 0;
      end else if (need == 1) begin
         sam_link[nl] = q;
      end else begin
         clone_cnt++;
         cl = sam_count++;
         sam_link[cl] = sam_link[q];
         for (int i = 0; i < NUM_SYM; i++) sam_next[cl*NUM_SYM+i] = sam_next[q*NUM_SYM+i];
         sam_len[cl] = sam_len[p] + 1;
         forever begin
            if (sam_next[p*NUM_SYM+c] != q) break;
            sam_next[p*NUM_SYM+c] = cl;
            if (p == 0) break;
            p = sam_link[p];
         end
         sam_link[q] = cl;
         sam_link[nl] = cl;
      end
      sam_last = nl;
      return 0;
   endfunction

   function automatic void walk_query(int unsigned c, bit ok);
      int unsigned pos, p;
      pos = qry_pos;
      p = qry_state;
      if (qry_pos < 65535) qry_pos++;
      if (p >= sam_count) begin
         p = 0;
         qry_len = 0;
      end
      if (!ok) begin
         qry_state = 0;
         qry_len = 0;
         return;
      end
      if (sam_next[p*NUM_SYM+c] == 0) begin
         forever begin
            if (sam_next[p*NUM_SYM+c] != 0) break;
            if (p == 0) begin
               qry_state = 0;
               qry_len = 0;
               return;
            end
            p = sam_link[p];
         end
         qry_len = sam_len[p];
      end
      qry_state = sam_next[p*NUM_SYM+c];
      qry_len++;
      if (qry_len > qry_best) begin
         qry_best = qry_len;
         qry_best_end = pos;
      end
   endfunction

   function automatic match_rsp_type predict_rsp(sym_item_type it);
      match_rsp_type r;
      bit ok, full;
      ok = it.symbol < NUM_SYM;
      full = 0;
      case (it.kind)
         sac_pkg::KIND_CLEAR: begin
            clear_automaton();
         end
         sac_pkg::KIND_APPEND: begin
            append_cnt++;
            if (ok) full = extend_text(it.symbol);
            if (full) drop_cnt++;
         end
         sac_pkg::KIND_MATCH: begin
            match_cnt++;
            if (it.first) begin
               qry_state = 0;
               qry_len = 0;
               qry_best = 0;
               qry_best_end = 0;
               qry_pos = 0;
            end
            walk_query(ok ? it.symbol : 0, ok);
         end
         default: ;
      endcase
      if (qry_best > top_best) top_best = qry_best;
      r.match_len = qry_len[sac_pkg::MLEN_W-1:0];
      r.best_len = qry_best[sac_pkg::MLEN_W-1:0];
      r.best_end = qry_best_end[sac_pkg::POS_W-1:0];
      r.full_res = full;
      return r;
   endfunction

   function automatic void push_item(logic [sac_pkg::KIND_W-1:0] k, int unsigned s, bit f);
      sym_item_type it;
      it.kind = k;
      it.symbol = s[sac_pkg::SYM_W-1:0];
      it.first = f;
      pending_items.insert(pending_items.size(), it);
   endfunction

   function automatic bit idle_now();
      if (cycle_cnt > 5000 && cycle_cnt < 12000) return 0;
      return $urandom_range(0, 99) < 7;
   endfunction

   // driver
   always @(posedge clock) begin
      sym_item_type it;
      cycle_cnt <= cycle_cnt + 1;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            it.kind = req_kind;
            it.symbol = req_symbol;
            it.first = req_first;
            expected_rsps.insert(expected_rsps.size(), predict_rsp(it));
         end
         if (pending_items.size() != 0 && !idle_now()) begin
            it = pending_items.pop_front();
            req_kind <= it.kind;
            req_symbol <= it.symbol;
            req_first <= it.first;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      match_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_cnt++;
            if (expected_rsps.size() == 0) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("unexpected transfer: match %0d best %0d end %0d full %0b",
                           rsp_match_len, rsp_best_len, rsp_best_end, rsp_full_res);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_match_len !== want.match_len || rsp_best_len !== want.best_len ||
                   rsp_best_end !== want.best_end || rsp_full_res !== want.full_res) begin
                  mismatch_cnt++;
                  if (mismatch_cnt <= 10)
                     $display("transfer %0d: exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                              rsp_cnt, want.match_len, want.best_len, want.best_end,
                              want.full_res, rsp_match_len, rsp_best_len, rsp_best_end,
                              rsp_full_res);
               end
            end
         end
         rsp_ready <= !idle_now();
      end
   end

   always @(posedge clock) begin
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_cnt);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      int unsigned k, n;
      for (int i = 0; i < NUM_STATES*NUM_SYM; i++) sam_next[i] = 0;
      for (int i = 0; i < NUM_STATES; i++) begin
         sam_link[i] = 0;
         sam_len[i] = 0;
      end
      clear_automaton();
      qry_best = 0;
      qry_best_end = 0;
      qry_pos = 0;

      // directed
      push_item(sac_pkg::KIND_MATCH, 0, 1'b1);
      push_item(sac_pkg::KIND_APPEND, 0, 1'b0);
      push_item(sac_pkg::KIND_APPEND, 25, 1'b1);
      push_item(sac_pkg::KIND_APPEND, 26, 1'b0);
      push_item(sac_pkg::KIND_APPEND, 31, 1'b0);
      push_item(sac_pkg::KIND_CLEAR, 31, 1'b1);
      push_item(sac_pkg::KIND_APPEND, 0, 1'b0);
      push_item(sac_pkg::KIND_APPEND, 1, 1'b0);
      push_item(sac_pkg::KIND_APPEND, 1, 1'b0);
      push_item(sac_pkg::KIND_MATCH, 0, 1'b1);
      push_item(sac_pkg::KIND_MATCH, 1, 1'b0);
      push_item(sac_pkg::KIND_MATCH, 1, 1'b0);
      push_item(sac_pkg::KIND_MATCH, 31, 1'b0);
      push_item(sac_pkg::KIND_MATCH, 1, 1'b0);
      push_item(sac_pkg::KIND_MATCH, 25, 1'b0);
      push_item(sac_pkg::KIND_UNUSED, 17, 1'b1);
      push_item(sac_pkg::KIND_CLEAR, 0, 1'b0);
      push_item(sac_pkg::KIND_MATCH, 1, 1'b0);
      push_item(sac_pkg::KIND_MATCH, 0, 1'b1);

      // random text and query rounds
      while (pending_items.size() < 1100) begin
         if ($urandom_range(0, 3) == 0)
            push_item(sac_pkg::KIND_CLEAR, $urandom_range(0, 31), 1'($urandom_range(0, 1)));
         k = ($urandom_range(0, 5) == 0) ? NUM_SYM : $urandom_range(1, 4);
         n = $urandom_range(1, 40);
         repeat (n) begin
            if ($urandom_range(0, 99) < 3)
               push_item(sac_pkg::KIND_APPEND, $urandom_range(26, 31),
                         1'($urandom_range(0, 1)));
            else if ($urandom_range(0, 99) < 3)
               push_item(sac_pkg::KIND_MATCH, $urandom_range(0, k-1), 1'b0);
            else
               push_item(sac_pkg::KIND_APPEND, $urandom_range(0, k-1),
                         1'($urandom_range(0, 1)));
         end
         push_item(sac_pkg::KIND_MATCH, $urandom_range(0, k-1), 1'b1);
         n = $urandom_range(1, 30);
         repeat (n) begin
            if ($urandom_range(0, 99) < 3)
               push_item(sac_pkg::KIND_UNUSED, $urandom_range(0, 31),
                         1'($urandom_range(0, 1)));
            else if ($urandom_range(0, 99) < 3)
               push_item(sac_pkg::KIND_MATCH, $urandom_range(26, 31), 1'b0);
            else
               push_item(sac_pkg::KIND_MATCH, $urandom_range(0, k-1),
                         $urandom_range(0, 99) < 5);
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      wait (pending_items.size() == 0 && !req_valid && expected_rsps.size() == 0);
      repeat (200) @(posedge clock);
      $display("%0d transfers: %0d appends (%0d dropped, %0d clones), %0d matches",
               rsp_cnt, append_cnt, drop_cnt, clone_cnt, match_cnt);
      $display("longest common substring seen %0d, last query position %0d",
               top_best, qry_pos);
      if (mismatch_cnt == 0 && expected_rsps.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", mismatch_cnt);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
